[sv/assert_macros.svh]
// assertion macros included by the pairwise correlation rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// concurrent check on clk, off while rst is high
`define PCL_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pcl check failed");
// concurrent check on clk, also during reset
`define PCL_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) else $error("pcl check failed");
`else
`define PCL_ASSERT(name, prop)
`define PCL_ASSERT_ALWAYS(name, prop)
`endif
`endif

[sv/pcl_pkg.sv]
// shared constants and types of the pairwise correlation block
package pcl_pkg;

  localparam int MAX_NODES   = 64;
  localparam int MAX_VOLUMES = 256;
  localparam int STORE_DEPTH = MAX_NODES * MAX_VOLUMES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int TOTAL_W     = ADDR_W + 1;
  localparam int TCNT_W      = $clog2(MAX_VOLUMES);
  localparam int NODE_W      = 7;
  localparam int VOL_W       = 9;
  localparam int IDX_W       = 6;
  localparam int SAMPLE_W    = 24;
  localparam int CORR_W      = 16;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int Q_W         = 21;
  localparam int STEP_W      = 7;
  localparam int EXP_W       = 5;

  localparam logic [NODE_W-1:0] NODES_MIN = 7'd2;
  localparam logic [NODE_W-1:0] NODES_MAX = 7'(MAX_NODES);
  localparam logic [VOL_W-1:0]  VOLS_MIN  = 9'd2;
  localparam logic [VOL_W-1:0]  VOLS_MAX  = 9'(MAX_VOLUMES);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PAIR = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCLUDE     = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_VAR = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_PAIR  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FIND, ST_RX, ST_RY, ST_MXX, ST_MXY, ST_MYY, ST_DIFF, ST_DCHK,
    ST_NORMX, ST_NORMY, ST_SQRTX, ST_SQRTY, ST_DEN, ST_DENW, ST_QINT, ST_QFRAC,
    ST_ROUND, ST_NEXT, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    ACC_NONE, ACC_SXX, ACC_SYY, ACC_SXY, ACC_DX, ACC_DY, ACC_DXY, ACC_DEN
  } acc_t;

  typedef enum logic [1:0] {
    MOP_ADD, MOP_ADD_HI, MOP_SUB, MOP_LOAD
  } mop_t;

  typedef struct packed {
    acc_t dest;
    mop_t op;
  } mreq_t;

endpackage

[sv/pairwise_correlation_lower_triangle.sv]
// pearson correlation over node pairs of a loaded sample matrix
//
// channel   dir  handshake                 payload
// item      in   item_valid / item_stall   op, sample
// result    out  result_valid / result_stall correlation, row_node, col_node, status, last
// cfg       in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// a load item (op 0) is written to the sample store and gives no result
// a pair request runs the pair search and the moments: one ram read port and
//   one shared 33x33 multiplier give the states RX, RY, MXX, MXY, MYY per volume, then
//   normalize, a 32 step square root per column, a shift-subtract divide up to 76 steps
// item_stall is high for the whole request; a finished result waits in an output
//   register so the next item is taken while the result is still stalled
// synchronous active high reset; the sample store is not cleared, no clearing pass
`include "assert_macros.svh"
module pairwise_correlation_lower_triangle (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              op,
  input  logic signed [pcl_pkg::SAMPLE_W-1:0] sample,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [pcl_pkg::CORR_W-1:0] correlation,
  output logic [pcl_pkg::IDX_W-1:0]         row_node,
  output logic [pcl_pkg::IDX_W-1:0]         col_node,
  output logic [pcl_pkg::STATUS_W-1:0]      status,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pcl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcl_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // configuration registers
  logic [pcl_pkg::NODE_W-1:0] node_count;
  logic [pcl_pkg::VOL_W-1:0]  volume_count;
  logic                       exclude_cross_half;

  // clamped sizes
  logic [pcl_pkg::NODE_W-1:0]  n_eff;
  logic [pcl_pkg::NODE_W-1:0]  half;
  logic [pcl_pkg::VOL_W-1:0]   v_eff;
  logic [pcl_pkg::TOTAL_W-1:0] total;

  // load cursor and enumeration cursor
  logic [pcl_pkg::ADDR_W-1:0]  load_position;
  logic [pcl_pkg::ADDR_W-1:0]  lp_cur;
  logic [pcl_pkg::TOTAL_W-1:0] lp_inc;
  logic [pcl_pkg::IDX_W-1:0]   pair_row;
  logic [pcl_pkg::IDX_W-1:0]   pair_col;
  logic                        enum_done;

  pcl_pkg::state_t state, state_next;

  // pair search
  logic [pcl_pkg::NODE_W-1:0] wr, wc;
  logic [pcl_pkg::NODE_W-1:0] wr_step, wc_step;
  logic                       f_none, f_lower, f_adm, f_found;
  logic [pcl_pkg::IDX_W-1:0]  cur_r, cur_c;

  // moments
  logic [pcl_pkg::TCNT_W-1:0]   tcnt;
  logic [pcl_pkg::ADDR_W-1:0]   base;
  logic signed [pcl_pkg::SAMPLE_W-1:0] xs, ys;
  logic [pcl_pkg::SAMPLE_W-1:0] ram_rdata;
  logic [pcl_pkg::ADDR_W-1:0]   ram_raddr;
  logic                         ram_we;
  logic signed [31:0] sx, sy;
  logic [63:0] sxx, syy, sxy, dx, dy, dxy, den;
  logic [3:0]  dstep;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_full;
  logic [63:0]        prod;
  pcl_pkg::mreq_t     mul_req, pend;

  // normalize, root, divide
  logic [pcl_pkg::EXP_W-1:0] ex, ey;
  logic [63:0] sq_res, sq_bit, sq_x, sq_sum, sq_res_new;
  logic        sq_ge;
  logic [31:0] rx, ry;
  logic [63:0] rem;
  logic [63:0] rem2, rem2_sub;
  logic        rem2_ge;
  logic [pcl_pkg::Q_W-1:0]    q;
  logic [pcl_pkg::Q_W-1:0]    qr;
  logic [16:0]                mag17;
  logic                       neg_r;
  logic [pcl_pkg::STEP_W-1:0] fstep, fsteps;

  // pending result
  logic [pcl_pkg::CORR_W-1:0]   res_corr;
  logic [pcl_pkg::IDX_W-1:0]    res_row, res_col;
  logic [pcl_pkg::STATUS_W-1:0] res_status;
  logic                         res_last;
  logic                         out_load;
  logic                         accept;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != pcl_pkg::ST_IDLE);
  assign accept     = item_valid && !item_stall;

  always_comb begin
    if (node_count < pcl_pkg::NODES_MIN) begin
      n_eff = pcl_pkg::NODES_MIN;
    end else if (node_count > pcl_pkg::NODES_MAX) begin
      n_eff = pcl_pkg::NODES_MAX;
    end else begin
      n_eff = node_count;
    end
    if (volume_count < pcl_pkg::VOLS_MIN) begin
      v_eff = pcl_pkg::VOLS_MIN;
    end else if (volume_count > pcl_pkg::VOLS_MAX) begin
      v_eff = pcl_pkg::VOLS_MAX;
    end else begin
      v_eff = volume_count;
    end
  end

  assign half  = n_eff >> 1;
  assign total = pcl_pkg::TOTAL_W'({8'b0, n_eff} * {6'b0, v_eff});

  // a position left beyond the matrix wraps to zero first
  assign lp_cur = ({1'b0, load_position} >= total) ? '0 : load_position;
  assign lp_inc = {1'b0, lp_cur} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count         <= pcl_pkg::NODES_MAX;
      volume_count       <= pcl_pkg::VOLS_MAX;
      exclude_cross_half <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pcl_pkg::CFG_NODE_COUNT:   node_count <= cfg_data[pcl_pkg::NODE_W-1:0];
        pcl_pkg::CFG_VOLUME_COUNT: volume_count <= cfg_data;
        pcl_pkg::CFG_EXCLUDE:      exclude_cross_half <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // one search step: a lower pair in different halves jumps to the first column of
  // the upper half, a finished row moves to the next row
  assign f_none  = (wr >= n_eff);
  assign f_lower = (wc < wr);
  assign f_adm   = !exclude_cross_half || ((wr < half) == (wc < half));
  assign f_found = !f_none && f_lower && f_adm;
  always_comb begin
    if (f_lower) begin
      wr_step = wr;
      wc_step = half;
    end else begin
      wr_step = wr + 1'b1;
      wc_step = '0;
    end
  end

  // sample store
  assign ram_we = accept && (op == pcl_pkg::OP_LOAD);

  pcl_ram #(
    .WIDTH(pcl_pkg::SAMPLE_W),
    .DEPTH(pcl_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(lp_cur),
    .wdata(sample),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // square root step
  assign sq_x       = (state == pcl_pkg::ST_SQRTX) ? dx : dy;
  assign sq_sum     = sq_res + sq_bit;
  assign sq_ge      = (sq_x >= sq_sum);
  assign sq_res_new = sq_ge ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);

  // fraction step of the divide, the doubled remainder wraps at 64 bits
  assign rem2     = {rem[62:0], 1'b0};
  assign rem2_ge  = (rem2 >= den);
  assign rem2_sub = rem2 - den;
  assign fsteps   = pcl_pkg::STEP_W'(ex) + pcl_pkg::STEP_W'(ey) + 7'd16;

  // round half away from zero, then saturate
  assign qr    = pcl_pkg::Q_W'((22'(q) + 22'd1) >> 1);
  assign mag17 = (qr > 21'd32768) ? 17'h08000 : qr[16:0];

  assign prod_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    mul_a        = '0;
    mul_b        = '0;
    mul_req.dest = pcl_pkg::ACC_NONE;
    mul_req.op   = pcl_pkg::MOP_ADD;
    ram_raddr    = base + pcl_pkg::ADDR_W'(cur_c);
    out_load     = 1'b0;
    unique case (state)
      pcl_pkg::ST_IDLE: begin
        if (accept && op == pcl_pkg::OP_PAIR) begin
          state_next = pcl_pkg::ST_FIND;
        end
      end
      pcl_pkg::ST_FIND: begin
        if (enum_done || f_none) begin
          state_next = pcl_pkg::ST_OUT;
        end else if (f_found) begin
          state_next = pcl_pkg::ST_RX;
        end
      end
      pcl_pkg::ST_RX: begin
        ram_raddr  = base + pcl_pkg::ADDR_W'(cur_r);
        state_next = pcl_pkg::ST_RY;
      end
      pcl_pkg::ST_RY: begin
        state_next = pcl_pkg::ST_MXX;
      end
      pcl_pkg::ST_MXX: begin
        mul_a      = 33'(xs);
        mul_b      = 33'(xs);
        mul_req    = '{pcl_pkg::ACC_SXX, pcl_pkg::MOP_ADD};
        state_next = pcl_pkg::ST_MXY;
      end
      pcl_pkg::ST_MXY: begin
        mul_a      = 33'(xs);
        mul_b      = 33'(ys);
        mul_req    = '{pcl_pkg::ACC_SXY, pcl_pkg::MOP_ADD};
        state_next = pcl_pkg::ST_MYY;
      end
      pcl_pkg::ST_MYY: begin
        mul_a   = 33'(ys);
        mul_b   = 33'(ys);
        mul_req = '{pcl_pkg::ACC_SYY, pcl_pkg::MOP_ADD};
        if ({1'b0, tcnt} == v_eff - 1'b1) begin
          state_next = pcl_pkg::ST_DIFF;
        end else begin
          state_next = pcl_pkg::ST_RX;
        end
      end
      pcl_pkg::ST_DIFF: begin
        // v*S(ab) split in low and high words, minus S(a)*S(b)
        unique case (dstep)
          4'd0: begin
            mul_a = {24'b0, v_eff}; mul_b = {1'b0, sxx[31:0]};
            mul_req = '{pcl_pkg::ACC_DX, pcl_pkg::MOP_ADD};
          end
          4'd1: begin
            mul_a = {24'b0, v_eff}; mul_b = {sxx[63], sxx[63:32]};
            mul_req = '{pcl_pkg::ACC_DX, pcl_pkg::MOP_ADD_HI};
          end
          4'd2: begin
            mul_a = 33'(sx); mul_b = 33'(sx);
            mul_req = '{pcl_pkg::ACC_DX, pcl_pkg::MOP_SUB};
          end
          4'd3: begin
            mul_a = {24'b0, v_eff}; mul_b = {1'b0, syy[31:0]};
            mul_req = '{pcl_pkg::ACC_DY, pcl_pkg::MOP_ADD};
          end
          4'd4: begin
            mul_a = {24'b0, v_eff}; mul_b = {syy[63], syy[63:32]};
            mul_req = '{pcl_pkg::ACC_DY, pcl_pkg::MOP_ADD_HI};
          end
          4'd5: begin
            mul_a = 33'(sy); mul_b = 33'(sy);
            mul_req = '{pcl_pkg::ACC_DY, pcl_pkg::MOP_SUB};
          end
          4'd6: begin
            mul_a = {24'b0, v_eff}; mul_b = {1'b0, sxy[31:0]};
            mul_req = '{pcl_pkg::ACC_DXY, pcl_pkg::MOP_ADD};
          end
          4'd7: begin
            mul_a = {24'b0, v_eff}; mul_b = {sxy[63], sxy[63:32]};
            mul_req = '{pcl_pkg::ACC_DXY, pcl_pkg::MOP_ADD_HI};
          end
          4'd8: begin
            mul_a = 33'(sx); mul_b = 33'(sy);
            mul_req = '{pcl_pkg::ACC_DXY, pcl_pkg::MOP_SUB};
          end
          default: ;
        endcase
        if (dstep == 4'd8) begin
          state_next = pcl_pkg::ST_DCHK;
        end
      end
      pcl_pkg::ST_DCHK: begin
        if (dx == '0 || dy == '0) begin
          state_next = pcl_pkg::ST_OUT;
        end else begin
          state_next = pcl_pkg::ST_NORMX;
        end
      end
      pcl_pkg::ST_NORMX: begin
        if (dx[63:60] != 4'b0) begin
          state_next = pcl_pkg::ST_NORMY;
        end
      end
      pcl_pkg::ST_NORMY: begin
        if (dy[63:60] != 4'b0) begin
          state_next = pcl_pkg::ST_SQRTX;
        end
      end
      pcl_pkg::ST_SQRTX: begin
        if (sq_bit[0]) begin
          state_next = pcl_pkg::ST_SQRTY;
        end
      end
      pcl_pkg::ST_SQRTY: begin
        if (sq_bit[0]) begin
          state_next = pcl_pkg::ST_DEN;
        end
      end
      pcl_pkg::ST_DEN: begin
        mul_a      = {1'b0, rx};
        mul_b      = {1'b0, ry};
        mul_req    = '{pcl_pkg::ACC_DEN, pcl_pkg::MOP_LOAD};
        state_next = pcl_pkg::ST_DENW;
      end
      pcl_pkg::ST_DENW: begin
        state_next = pcl_pkg::ST_QINT;
      end
      pcl_pkg::ST_QINT: begin
        if (rem < den) begin
          state_next = pcl_pkg::ST_QFRAC;
        end
      end
      pcl_pkg::ST_QFRAC: begin
        if (q[pcl_pkg::Q_W-1] || fstep == fsteps) begin
          state_next = pcl_pkg::ST_ROUND;
        end
      end
      pcl_pkg::ST_ROUND: begin
        state_next = pcl_pkg::ST_NEXT;
      end
      pcl_pkg::ST_NEXT: begin
        if (f_none || f_found) begin
          state_next = pcl_pkg::ST_OUT;
        end
      end
      pcl_pkg::ST_OUT: begin
        if (!result_valid || !result_stall) begin
          out_load   = 1'b1;
          state_next = pcl_pkg::ST_IDLE;
        end
      end
      default: state_next = pcl_pkg::ST_IDLE;
    endcase
  end

  // load cursor, enumeration cursor and done flag
  always_ff @(posedge clk) begin
    if (rst) begin
      load_position <= '0;
      pair_row      <= pcl_pkg::IDX_W'(1);
      pair_col      <= '0;
      enum_done     <= 1'b0;
    end else begin
      if (ram_we) begin
        // a load at position zero starts a new matrix
        if (lp_cur == '0) begin
          pair_row  <= pcl_pkg::IDX_W'(1);
          pair_col  <= '0;
          enum_done <= 1'b0;
        end
        load_position <= (lp_inc >= total) ? '0 : lp_inc[pcl_pkg::ADDR_W-1:0];
      end
      if (state == pcl_pkg::ST_FIND && (enum_done || f_none)) begin
        enum_done <= 1'b1;
      end
      if (state == pcl_pkg::ST_DCHK && (dx == '0 || dy == '0)) begin
        enum_done <= 1'b1;
      end
      if (state == pcl_pkg::ST_NEXT) begin
        if (f_none) begin
          enum_done <= 1'b1;
        end else if (f_found) begin
          pair_row <= wr[pcl_pkg::IDX_W-1:0];
          pair_col <= wc[pcl_pkg::IDX_W-1:0];
        end
      end
    end
  end

  // multiplier control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '{pcl_pkg::ACC_NONE, pcl_pkg::MOP_ADD};
    end else begin
      pend <= mul_req;
    end
  end

  function automatic logic [63:0] acc_apply(input logic [63:0] acc, input pcl_pkg::mop_t mop,
                                            input logic [63:0] p);
    logic [63:0] r;
    unique case (mop)
      pcl_pkg::MOP_ADD:    r = acc + p;
      pcl_pkg::MOP_ADD_HI: r = acc + {p[31:0], 32'b0};
      pcl_pkg::MOP_SUB:    r = acc - p;
      pcl_pkg::MOP_LOAD:   r = p;
      default:             r = acc;
    endcase
    return r;
  endfunction

  // datapath
  always_ff @(posedge clk) begin
    prod <= prod_full[63:0];

    unique case (pend.dest)
      pcl_pkg::ACC_SXX: sxx <= acc_apply(sxx, pend.op, prod);
      pcl_pkg::ACC_SYY: syy <= acc_apply(syy, pend.op, prod);
      pcl_pkg::ACC_SXY: sxy <= acc_apply(sxy, pend.op, prod);
      pcl_pkg::ACC_DX:  dx  <= acc_apply(dx, pend.op, prod);
      pcl_pkg::ACC_DY:  dy  <= acc_apply(dy, pend.op, prod);
      pcl_pkg::ACC_DXY: dxy <= acc_apply(dxy, pend.op, prod);
      pcl_pkg::ACC_DEN: den <= acc_apply(den, pend.op, prod);
      default: ;
    endcase

    unique case (state)
      pcl_pkg::ST_IDLE: begin
        wr <= {1'b0, pair_row};
        wc <= {1'b0, pair_col};
      end
      pcl_pkg::ST_FIND: begin
        if (enum_done || f_none) begin
          res_corr   <= '0;
          res_row    <= '0;
          res_col    <= '0;
          res_status <= pcl_pkg::STATUS_NO_PAIR;
          res_last   <= 1'b0;
        end else if (f_found) begin
          cur_r <= wr[pcl_pkg::IDX_W-1:0];
          cur_c <= wc[pcl_pkg::IDX_W-1:0];
          tcnt  <= '0;
          base  <= '0;
          sx    <= '0;
          sy    <= '0;
          sxx   <= '0;
          syy   <= '0;
          sxy   <= '0;
          dx    <= '0;
          dy    <= '0;
          dxy   <= '0;
          dstep <= '0;
          ex    <= '0;
          ey    <= '0;
        end else begin
          wr <= wr_step;
          wc <= wc_step;
        end
      end
      pcl_pkg::ST_RY: begin
        xs <= ram_rdata;
      end
      pcl_pkg::ST_MXX: begin
        ys <= ram_rdata;
        sx <= sx + 32'(xs);
      end
      pcl_pkg::ST_MXY: begin
        sy <= sy + 32'(ys);
      end
      pcl_pkg::ST_MYY: begin
        tcnt <= tcnt + 1'b1;
        base <= base + pcl_pkg::ADDR_W'(n_eff);
      end
      pcl_pkg::ST_DIFF: begin
        dstep <= dstep + 1'b1;
      end
      pcl_pkg::ST_DCHK: begin
        res_row  <= cur_r;
        res_col  <= cur_c;
        res_corr <= '0;
        res_status <= pcl_pkg::STATUS_ZERO_VAR;
        res_last <= 1'b1;
      end
      pcl_pkg::ST_NORMX: begin
        if (dx[63:60] == 4'b0) begin
          dx <= dx << 2;
          ex <= ex + 1'b1;
        end
      end
      pcl_pkg::ST_NORMY: begin
        if (dy[63:60] == 4'b0) begin
          dy <= dy << 2;
          ey <= ey + 1'b1;
        end
        sq_res <= '0;
        sq_bit <= 64'h4000_0000_0000_0000;
      end
      pcl_pkg::ST_SQRTX: begin
        if (sq_ge) begin
          dx <= dx - sq_sum;
        end
        if (sq_bit[0]) begin
          rx     <= sq_res_new[31:0];
          sq_res <= '0;
          sq_bit <= 64'h4000_0000_0000_0000;
        end else begin
          sq_res <= sq_res_new;
          sq_bit <= sq_bit >> 2;
        end
      end
      pcl_pkg::ST_SQRTY: begin
        if (sq_ge) begin
          dy <= dy - sq_sum;
        end
        sq_res <= sq_res_new;
        sq_bit <= sq_bit >> 2;
        if (sq_bit[0]) begin
          ry <= sq_res_new[31:0];
        end
      end
      pcl_pkg::ST_DEN: begin
        neg_r <= dxy[63];
        rem   <= dxy[63] ? (64'd0 - dxy) : dxy;
        q     <= '0;
      end
      pcl_pkg::ST_QINT: begin
        // quotient below 16 since den is at least 2^60
        if (rem >= den) begin
          rem <= rem - den;
          q   <= q + 1'b1;
        end
        fstep <= '0;
      end
      pcl_pkg::ST_QFRAC: begin
        if (!(q[pcl_pkg::Q_W-1] || fstep == fsteps)) begin
          rem   <= rem2_ge ? rem2_sub : rem2;
          q     <= {q[pcl_pkg::Q_W-2:0], rem2_ge};
          fstep <= fstep + 1'b1;
        end
      end
      pcl_pkg::ST_ROUND: begin
        if (neg_r) begin
          res_corr <= pcl_pkg::CORR_W'(17'h10000 - mag17);
        end else if (qr > 21'd32767) begin
          res_corr <= 16'h7FFF;
        end else begin
          res_corr <= qr[pcl_pkg::CORR_W-1:0];
        end
        res_row    <= cur_r;
        res_col    <= cur_c;
        res_status <= pcl_pkg::STATUS_OK;
        wr <= {1'b0, cur_r};
        wc <= {1'b0, cur_c} + 1'b1;
      end
      pcl_pkg::ST_NEXT: begin
        if (f_none) begin
          res_last <= 1'b1;
        end else if (f_found) begin
          res_last <= 1'b0;
        end else begin
          wr <= wr_step;
          wc <= wc_step;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      correlation <= res_corr;
      row_node    <= res_row;
      col_node    <= res_col;
      status      <= res_status;
      last        <= res_last;
    end
  end

  `PCL_ASSERT(a_no_pair_fields, result_valid && status == pcl_pkg::STATUS_NO_PAIR |-> row_node == '0 && col_node == '0 && !last && correlation == '0)
  `PCL_ASSERT(a_pair_order, result_valid && status == pcl_pkg::STATUS_OK |-> row_node > col_node)
  `PCL_ASSERT(a_fail_ends_run, state == pcl_pkg::ST_DCHK && (dx == '0 || dy == '0) |=> enum_done)
  `PCL_ASSERT(a_roots_normalized, state == pcl_pkg::ST_DEN |-> rx[31:30] != 2'b00 && ry[31:30] != 2'b00)
  `PCL_ASSERT(a_rem_below_den, state == pcl_pkg::ST_QFRAC |-> rem < den)

endmodule

[sv/pcl_ram.sv]
// generic single write port ram with registered read
module pcl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
